// ----- hw/rtl/priority_channel_arbiter_assert.svh -----
// Assertion macros used by the checker module of the channel arbiter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef PRIORITY_CHANNEL_ARBITER_ASSERT_SVH
`define PRIORITY_CHANNEL_ARBITER_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define PCA_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising edge outside reset.
`define PCA_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/pca_pkg.sv -----
// Package of the priority channel arbiter: sizes, codes and the queue item type.
// Depends on nothing; used by pca_front, pca_back and the top level of the arbiter.
package pca_pkg;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned SlotW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW = 48;

  localparam logic OpRequest = 1'b0;
  localparam logic OpRelease = 1'b1;
  localparam logic StatusGrant = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  flow_id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] duration;
  } item_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] duration;
    logic [7:0]  flow_id;
  } entry_t;
endpackage

// ----- hw/rtl/pca_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/pca_front.sv -----
// Front part of the arbiter: a two-entry queue that takes items from the input channel.
// Depends on pca_pkg.
module pca_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  pca_pkg::item_t in_item_i,
  output logic           q_valid_o,
  input  logic           q_pop_i,
  output pca_pkg::item_t q_item_o
);
  pca_pkg::item_t buf_q [2];
  logic           rd_q, wr_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (q_pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ----- hw/rtl/pca_back.sv -----
// Back part of the arbiter: the waiting store, a slot-by-slot scan and the output register.
// Depends on pca_pkg and pca_ram.
module pca_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  pca_pkg::item_t q_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     granted_id_o,
  output logic           status_o
);
  typedef enum logic [2:0] {
    StIdle, StScan, StScanLast, StPick, StOut
  } state_e;

  state_e                    state_q;
  logic [pca_pkg::QueueDepth-1:0] valid_q;
  logic                      busy_q;
  logic [pca_pkg::SlotW-1:0] idx_q, rd_idx_q, best_idx_q;
  logic                      rd_ok_q, best_ok_q;
  pca_pkg::entry_t           best_q;
  logic [pca_pkg::EntryW-1:0] rdata;
  pca_pkg::entry_t           rd_entry;
  logic                      we;
  logic [pca_pkg::SlotW-1:0] free_idx, raddr;
  logic                      free_ok;
  logic                      beats;

  assign rd_entry = pca_pkg::entry_t'(rdata);
  assign beats = {rd_entry.prio, rd_entry.arrival, rd_entry.duration, rd_entry.flow_id} <
                 {best_q.prio, best_q.arrival, best_q.duration, best_q.flow_id};

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int k = pca_pkg::QueueDepth - 1; k >= 0; k--) begin
      if (!valid_q[k]) begin
        free_ok = 1'b1;
        free_idx = pca_pkg::SlotW'(k);
      end
    end
  end

  assign we = (state_q == StIdle) && q_valid_i && (q_item_i.op == pca_pkg::OpRequest) &&
              (busy_q || (valid_q != '0)) && free_ok;
  assign raddr = idx_q;
  assign q_pop_o = (state_q == StIdle) && q_valid_i;

  pca_ram #(.Width(pca_pkg::EntryW), .Depth(pca_pkg::QueueDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx),
    .wdata_i ({q_item_i.prio, q_item_i.arrival, q_item_i.duration, q_item_i.flow_id}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      busy_q <= 1'b0;
      out_valid_o <= 1'b0;
      idx_q <= '0;
      rd_idx_q <= '0;
      best_idx_q <= '0;
      rd_ok_q <= 1'b0;
      best_ok_q <= 1'b0;
      best_q <= '0;
      granted_id_o <= '0;
      status_o <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            if (q_item_i.op == pca_pkg::OpRequest) begin
              if (!busy_q && (valid_q == '0)) begin
                busy_q <= 1'b1;
                granted_id_o <= q_item_i.flow_id;
                status_o <= pca_pkg::StatusGrant;
                out_valid_o <= 1'b1;
                state_q <= StOut;
              end else if (free_ok) begin
                valid_q[free_idx] <= 1'b1;
              end else begin
                granted_id_o <= q_item_i.flow_id;
                status_o <= pca_pkg::StatusReject;
                out_valid_o <= 1'b1;
                state_q <= StOut;
              end
            end else if (valid_q == '0) begin
              busy_q <= 1'b0;
            end else begin
              idx_q <= '0;
              rd_ok_q <= 1'b0;
              best_ok_q <= 1'b0;
              state_q <= StScan;
            end
          end
        end
        StScan, StScanLast: begin
          rd_ok_q <= valid_q[idx_q];
          rd_idx_q <= idx_q;
          if (rd_ok_q && (!best_ok_q || beats)) begin
            best_q <= rd_entry;
            best_idx_q <= rd_idx_q;
            best_ok_q <= 1'b1;
          end
          if (state_q == StScanLast) begin
            state_q <= StPick;
          end else if (idx_q == pca_pkg::SlotW'(pca_pkg::QueueDepth - 1)) begin
            state_q <= StScanLast;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StPick: begin
          if (rd_ok_q && (!best_ok_q || beats)) begin
            valid_q[rd_idx_q] <= 1'b0;
            granted_id_o <= rd_entry.flow_id;
          end else begin
            valid_q[best_idx_q] <= 1'b0;
            granted_id_o <= best_q.flow_id;
          end
          busy_q <= 1'b1;
          status_o <= pca_pkg::StatusGrant;
          out_valid_o <= 1'b1;
          state_q <= StOut;
        end
        StOut: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/priority_channel_arbiter.sv -----
// Top level of the non-preemptive priority channel arbiter.
// Depends on pca_pkg, pca_front and pca_back.
//
// The input channel takes request items (op 0) and release items (op 1) with
// in_valid_i and in_stall_o; the output channel gives one item with
// out_valid_o/out_stall_i handshake for each grant or rejection.
// A two-entry queue in front lets new items arrive while the back part works.
// A request on an idle channel with no waiters, or one rejected on a full
// store, gives its result item through the front queue and the result
// register; a queued request gives none.
// A release with waiters scans all QueueDepth slots of the waiting store, one
// slot a cycle through the registered read port of the store memory, and
// then goes through StScanLast and StPick before its result is registered.
// The back part takes its next item in the cycle after a result is taken.
// The result register holds the item while out_stall_i is high; no further
// item is processed until it is taken.
// Reset clears the channel, the valid bits of the store and the front queue; the
// store memory itself needs no clearing.
module priority_channel_arbiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  flow_id_i,
  input  logic [7:0]  prio_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] duration_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  granted_id_o,
  output logic        status_o
);
  pca_pkg::item_t in_item, q_item;
  logic           q_valid, q_pop;

  assign in_item = '{op: op_i, flow_id: flow_id_i, prio: prio_i,
                     arrival: arrival_i, duration: duration_i};

  pca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  pca_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .granted_id_o (granted_id_o),
    .status_o     (status_o)
  );
endmodule

// ----- hw/rtl/pca_checker.sv -----
// Port-level checker of the priority channel arbiter, bound to the top level.
// Depends on priority_channel_arbiter_assert.svh and priority_channel_arbiter.
`include "priority_channel_arbiter_assert.svh"
module pca_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       op_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] granted_id_o,
  input logic       status_o
);
  `PCA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `PCA_ASSERT_NXT(a_id_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(granted_id_o))
  `PCA_ASSERT_NXT(a_out_one, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)
  `PCA_ASSERT_IMP(a_first_grant, clk_i, rst_ni,
    $past(!rst_ni) && in_valid_i && !in_stall_o && op_i == 1'b0,
    ##2 (out_valid_o && status_o == 1'b0))
endmodule

bind priority_channel_arbiter pca_checker u_pca_checker (.*);
